@@ rtl/core/lpht_pkg.sv @@
// Shared types and constants for the linear-probing hash table.
// Holds the request and response word types, the slot entry type and the status codes.
// No dependencies.
`timescale 1ns / 1ps

package lpht_pkg;

	localparam int SLOTS    = 1024;
	localparam int KEY_BITS = 20;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int IDX_W    = 10;
	localparam int VAL_W    = 32;

	localparam logic [2:0] STATUS_FOUND     = 3'd0;
	localparam logic [2:0] STATUS_ABSENT    = 3'd1;
	localparam logic [2:0] STATUS_INSERTED  = 3'd2;
	localparam logic [2:0] STATUS_DUPLICATE = 3'd3;
	localparam logic [2:0] STATUS_FULL      = 3'd4;

	localparam logic MODE_SEARCH = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [19:0]       lookup_key;
		logic [VAL_W-1:0]  payload;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [IDX_W-1:0]  slot_index;
		logic [VAL_W-1:0]  stored_value;
	} rsp_t;

	typedef struct packed {
		logic                used;
		logic [KEY_BITS-1:0] key;
		logic [VAL_W-1:0]    value;
	} slot_t;

endpackage

@@ rtl/core/linear_probe_hash_table.sv @@
// Hash table with open addressing and linear probing over a slot memory with one read port and one write port.
// Depends on lpht_pkg for the word types, sizes and status codes.
`timescale 1ns / 1ps

// After reset the block sweeps the slot memory to mark every slot empty; req_stall stays
// high during that sweep. Each word is then accepted, probes slots in order from its home
// slot until it meets its key or an empty slot or has checked every slot, and hands its
// result to the output register; req_stall stays high until then, so a new word is only
// taken after the last one has resolved. The probe rate is set by the single read port
// of the slot memory, which reads one slot per cycle. A finished result waits in the
// output register while the next word is accepted.
module linear_probe_hash_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  lpht_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output lpht_pkg::rsp_t  rsp
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_RESP
	} state_t;

	state_t state_q;

	lpht_pkg::slot_t mem [lpht_pkg::SLOTS];
	lpht_pkg::slot_t rd_data_s1;

	logic [lpht_pkg::SLOT_W-1:0]   clr_q;
	logic                          mode_q;
	logic [lpht_pkg::KEY_BITS-1:0] key_q;
	logic [lpht_pkg::VAL_W-1:0]    payload_q;
	logic [lpht_pkg::SLOT_W-1:0]   pos_q;
	logic [lpht_pkg::SLOT_W:0]     iss_q;
	logic [lpht_pkg::SLOT_W-1:0]   ck_q;
	logic                          chk_s1;
	logic [lpht_pkg::SLOT_W-1:0]   addr_s1;
	lpht_pkg::rsp_t                res_q;
	lpht_pkg::rsp_t                rsp_q;
	logic                          rsp_valid_q;

	logic                          rd_en;
	logic                          wr_en;
	logic [lpht_pkg::SLOT_W-1:0]   wr_addr;
	lpht_pkg::slot_t               wr_data;
	logic                          hit;
	logic                          empty;
	logic                          last;
	logic                          done;
	lpht_pkg::rsp_t                res_d;
	logic [lpht_pkg::SLOT_W-1:0]   pos_next;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Reads are issued while fewer than SLOTS slots have been requested for this word.
	assign rd_en    = (state_q == ST_PROBE) && (iss_q != (lpht_pkg::SLOT_W + 1)'(lpht_pkg::SLOTS));
	assign pos_next = (pos_q == lpht_pkg::SLOT_W'(lpht_pkg::SLOTS - 1)) ?
		'0 : pos_q + lpht_pkg::SLOT_W'(1);

	assign hit   = rd_data_s1.used && (rd_data_s1.key == key_q);
	assign empty = !rd_data_s1.used;
	assign last  = (ck_q == lpht_pkg::SLOT_W'(lpht_pkg::SLOTS - 1));
	assign done  = (state_q == ST_PROBE) && chk_s1 && (hit || empty || last);

	always_comb begin
		res_d = '0;
		if (hit) begin
			res_d.status       = (mode_q == lpht_pkg::MODE_INSERT) ?
				lpht_pkg::STATUS_DUPLICATE : lpht_pkg::STATUS_FOUND;
			res_d.slot_index   = lpht_pkg::IDX_W'(addr_s1);
			res_d.stored_value = rd_data_s1.value;
		end else if (mode_q == lpht_pkg::MODE_SEARCH) begin
			res_d.status = lpht_pkg::STATUS_ABSENT;
		end else if (empty) begin
			res_d.status       = lpht_pkg::STATUS_INSERTED;
			res_d.slot_index   = lpht_pkg::IDX_W'(addr_s1);
			res_d.stored_value = payload_q;
		end else begin
			res_d.status = lpht_pkg::STATUS_FULL;
		end
	end

	// The one write port serves the clearing sweep and the insert of a new key.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data.used  = 1'b1;
		wr_data.key   = key_q;
		wr_data.value = payload_q;
		if (state_q == ST_CLEAR) begin
			wr_en        = 1'b1;
			wr_addr      = clr_q;
			wr_data.used = 1'b0;
		end else if (done && !hit && empty && (mode_q == lpht_pkg::MODE_INSERT)) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			mode_q      <= 1'b0;
			key_q       <= '0;
			payload_q   <= '0;
			pos_q       <= '0;
			iss_q       <= '0;
			ck_q        <= '0;
			chk_s1      <= 1'b0;
			addr_s1     <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// In ST_RESP a taken result is replaced by the next one below.
			if (rsp_valid_q && !rsp_stall && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + lpht_pkg::SLOT_W'(1);
					if (clr_q == lpht_pkg::SLOT_W'(lpht_pkg::SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						mode_q    <= req.mode;
						key_q     <= req.lookup_key[lpht_pkg::KEY_BITS-1:0];
						payload_q <= req.payload;
						// Home slot is the key modulo the slot count.
						pos_q     <= req.lookup_key[lpht_pkg::SLOT_W-1:0];
						iss_q     <= '0;
						ck_q      <= '0;
						chk_s1    <= 1'b0;
						state_q   <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (rd_en) begin
						pos_q   <= pos_next;
						iss_q   <= iss_q + (lpht_pkg::SLOT_W + 1)'(1);
						addr_s1 <= pos_q;
					end
					// A read still in flight when the word resolves is dropped.
					chk_s1 <= rd_en && !done;
					if (chk_s1) begin
						ck_q <= ck_q + lpht_pkg::SLOT_W'(1);
					end
					if (done) begin
						res_q   <= res_d;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/sv/linear_probe_hash_table_tb.sv @@
// Self-checking testbench for the linear-probing hash table: directed and random words
// against a mirror of the slot table kept in the bench, over several handshake pacings.
// Depends on lpht_pkg and linear_probe_hash_table.
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
	import lpht_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MIXED_WORDS = 500;
	localparam int FULL_WORDS  = 24;
	localparam int PLAN   = 0;
	localparam int MIRROR = 1;

	typedef enum logic [1:0] {PROBE_HIT, PROBE_EMPTY, PROBE_EXHAUSTED} probe_e;
	typedef enum logic [1:0] {PACE_STEADY, PACE_SLOW_SEND, PACE_SLOW_TAKE, PACE_BOTH} pace_e;

	typedef struct {
		req_t  word;
		pace_e pace;
		bit    drain;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Bank PLAN follows the table while words are queued; bank MIRROR follows accepted words.
	logic                tbl_used  [2][SLOTS];
	logic [KEY_BITS-1:0] tbl_key   [2][SLOTS];
	logic [VAL_W-1:0]    tbl_value [2][SLOTS];

	pending_t word_queue[$];
	rsp_t     pending_answers[$];
	rsp_t     due_rsp;
	pace_e    gen_pace = PACE_STEADY;
	pace_e    traffic = PACE_STEADY;
	bit       gen_drain = 1'b0;
	logic     req_took = 1'b0;
	int       total_words = 0;
	int       words_accepted = 0;
	int       results_seen = 0;
	int       error_count = 0;
	int       cycle_count = 0;

	linear_probe_hash_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic probe_e probe_slots(input int bank, input logic [KEY_BITS-1:0] key,
			output int pos);
		int p;
		p = key % SLOTS;
		pos = 0;
		for (int n = 0; n < SLOTS; n++) begin
			if (!tbl_used[bank][p]) begin
				pos = p;
				return PROBE_EMPTY;
			end
			if (tbl_key[bank][p] == key) begin
				pos = p;
				return PROBE_HIT;
			end
			p = (p + 1) % SLOTS;
		end
		return PROBE_EXHAUSTED;
	endfunction

	function automatic rsp_t table_access(input int bank, input req_t w);
		rsp_t r;
		probe_e outcome;
		int pos;
		r = '0;
		outcome = probe_slots(bank, w.lookup_key[KEY_BITS-1:0], pos);
		if (outcome == PROBE_HIT) begin
			r.status = (w.mode == MODE_INSERT) ? STATUS_DUPLICATE : STATUS_FOUND;
			r.slot_index = pos[IDX_W-1:0];
			r.stored_value = tbl_value[bank][pos];
		end else if (w.mode != MODE_INSERT) begin
			r.status = STATUS_ABSENT;
		end else if (outcome == PROBE_EMPTY) begin
			tbl_used[bank][pos] = 1'b1;
			tbl_key[bank][pos] = w.lookup_key[KEY_BITS-1:0];
			tbl_value[bank][pos] = w.payload;
			r.status = STATUS_INSERTED;
			r.slot_index = pos[IDX_W-1:0];
			r.stored_value = w.payload;
		end else begin
			r.status = STATUS_FULL;
		end
		return r;
	endfunction

	function automatic int pick_slot(input logic want_used);
		int start;
		int p;
		start = $urandom_range(SLOTS - 1);
		for (int n = 0; n < SLOTS; n++) begin
			p = (start + n) % SLOTS;
			if (tbl_used[PLAN][p] == want_used)
				return p;
		end
		return -1;
	endfunction

	// Keys whose home slot sits a few slots before an empty one, so probe runs stay short
	// but still collide and wrap.
	function automatic logic [KEY_BITS-1:0] key_near_empty();
		int e;
		int home;
		logic [KEY_BITS-SLOT_W-1:0] upper;
		logic [KEY_BITS-1:0] any_key;
		e = pick_slot(1'b0);
		any_key = KEY_BITS'($urandom());
		if (e < 0)
			return any_key;
		home = (e + SLOTS - $urandom_range(3)) % SLOTS;
		upper = (KEY_BITS - SLOT_W)'($urandom());
		return {upper, home[SLOT_W-1:0]};
	endfunction

	function automatic logic [KEY_BITS-1:0] key_in_use();
		int p;
		logic [KEY_BITS-1:0] any_key;
		p = pick_slot(1'b1);
		any_key = KEY_BITS'($urandom());
		if (p < 0)
			return any_key;
		return tbl_key[PLAN][p];
	endfunction

	function automatic logic [KEY_BITS-1:0] key_absent();
		logic [KEY_BITS-1:0] k;
		int p;
		do
			k = KEY_BITS'($urandom());
		while (probe_slots(PLAN, k, p) == PROBE_HIT);
		return k;
	endfunction

	function automatic bit idle_roll(input pace_e p, input bit receiver);
		int pct;
		case (p)
			PACE_SLOW_SEND: pct = receiver ? 0 : 77;
			PACE_SLOW_TAKE: pct = receiver ? 77 : 0;
			PACE_BOTH:      pct = 37;
			default:        pct = 0;
		endcase
		return $urandom_range(99) < pct;
	endfunction

	task automatic queue_word(input logic m, input logic [19:0] k, input logic [VAL_W-1:0] v);
		pending_t p;
		p.word.mode = m;
		p.word.lookup_key = k;
		p.word.payload = v;
		p.pace = gen_pace;
		p.drain = gen_drain;
		gen_drain = 1'b0;
		void'(table_access(PLAN, p.word));
		word_queue.push_back(p);
		total_words++;
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
				results_seen, name, got, want));
	endtask

	// Driver: a held word stays put until it is taken; a new word may wait on a random gap.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_took) begin
				if (word_queue.size() > 0)
					traffic = word_queue[0].pace;
				if (word_queue.size() > 0 && (!word_queue[0].drain || pending_answers.size() == 0)
						&& !idle_roll(traffic, 1'b0)) begin
					req <= word_queue[0].word;
					req_valid <= 1'b1;
					void'(word_queue.pop_front());
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= idle_roll(traffic, 1'b1);
		end
	end

	// Monitor: results are checked before the word taken in the same cycle is predicted.
	always @(posedge clk) begin
		req_took <= arst_n && req_valid && !req_stall;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no word pending",
					results_seen));
			end else begin
				due_rsp = pending_answers.pop_front();
				check_field("status", 32'(rsp.status), 32'(due_rsp.status));
				check_field("slot_index", 32'(rsp.slot_index), 32'(due_rsp.slot_index));
				check_field("stored_value", rsp.stored_value, due_rsp.stored_value);
			end
			results_seen++;
		end
		if (arst_n && req_valid && !req_stall) begin
			pending_answers.push_back(table_access(MIRROR, req));
			words_accepted++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int e;
		int n;
		int kind;
		logic [KEY_BITS-SLOT_W-1:0] upper;

		for (int b = 0; b < 2; b++)
			for (int s = 0; s < SLOTS; s++) begin
				tbl_used[b][s] = 1'b0;
				tbl_key[b][s] = '0;
				tbl_value[b][s] = '0;
			end

		// Directed: empty table, duplicates, a home-slot chain at the top that wraps to slot 0.
		queue_word(MODE_SEARCH, 20'h00000, 32'h0000_0000);
		queue_word(MODE_INSERT, 20'h00000, 32'h0000_0000);
		queue_word(MODE_SEARCH, 20'h00000, 32'hFFFF_FFFF);
		queue_word(MODE_INSERT, 20'h00000, 32'hFFFF_FFFF);
		queue_word(MODE_INSERT, 20'h00400, 32'hFFFF_FFFF);
		queue_word(MODE_SEARCH, 20'h00400, 32'h0000_0000);
		queue_word(MODE_INSERT, 20'hFFFFF, 32'hA5A5_5A5A);
		queue_word(MODE_INSERT, 20'h7FFFF, 32'h5A5A_A5A5);
		queue_word(MODE_SEARCH, 20'h7FFFF, 32'h0000_0000);
		queue_word(MODE_INSERT, 20'h003FF, 32'h1234_5678);
		queue_word(MODE_SEARCH, 20'h007FF, 32'hFFFF_FFFF);
		queue_word(MODE_INSERT, 20'h7FFFF, 32'h0000_0000);
		queue_word(MODE_SEARCH, 20'hFFFFF, 32'h0000_0000);
		queue_word(MODE_INSERT, 20'h55555, 32'h5555_5555);
		queue_word(MODE_INSERT, 20'hAAAAA, 32'hAAAA_AAAA);
		queue_word(MODE_SEARCH, 20'h55555, 32'h0000_0000);
		queue_word(MODE_SEARCH, 20'hAAAAA, 32'h0000_0000);
		queue_word(MODE_SEARCH, 20'h003FF, 32'h0000_0000);

		for (int i = 0; i < MIXED_WORDS; i++) begin
			if (i % (MIXED_WORDS / 4) == 0) begin
				gen_pace = pace_e'(i / (MIXED_WORDS / 4));
				gen_drain = 1'b1;
			end
			kind = $urandom_range(99);
			if (kind < 65)
				queue_word(MODE_INSERT, key_near_empty(), $urandom());
			else if (kind < 75)
				queue_word(MODE_SEARCH, key_in_use(), $urandom());
			else if (kind < 82)
				queue_word(MODE_SEARCH, key_near_empty(), $urandom());
			else if (kind < 90)
				queue_word(MODE_INSERT, key_in_use(), $urandom());
			else
				queue_word(1'($urandom_range(1)), KEY_BITS'($urandom()), $urandom());
		end

		// Fill every remaining slot from its own home so the table reaches full cheaply.
		n = 0;
		e = pick_slot(1'b0);
		while (e >= 0) begin
			if (n % 150 == 0)
				gen_pace = pace_e'((n / 150) % 4);
			upper = (KEY_BITS - SLOT_W)'($urandom());
			queue_word(MODE_INSERT, {upper, e[SLOT_W-1:0]}, $urandom());
			n++;
			e = pick_slot(1'b0);
		end

		// Full table: misses probe every slot, and inserts of new keys are refused.
		gen_drain = 1'b1;
		for (int i = 0; i < FULL_WORDS; i++) begin
			gen_pace = pace_e'(i % 4);
			case (i % 4)
				0: queue_word(MODE_SEARCH, key_in_use(), $urandom());
				1: queue_word(MODE_SEARCH, key_absent(), $urandom());
				2: queue_word(MODE_INSERT, key_absent(), $urandom());
				default: queue_word(MODE_INSERT, key_in_use(), $urandom());
			endcase
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_accepted != total_words || pending_answers.size() != 0)
			@(negedge clk);
		repeat (SLOTS + 16) @(negedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/lpht_pkg.sv
rtl/core/linear_probe_hash_table.sv
tb/sv/linear_probe_hash_table_tb.sv
